FILE: sv/assert_macros.svh
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: sv/bpfa_pkg.sv
// Package: types, constants and state encoding of the page frame allocator
package bpfa_pkg;
    localparam int PAGES      = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int WORDS      = (PAGES + 63) / 64;
    localparam int WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W       = $clog2(PAGES) + 1;
    localparam int RP_W       = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] size_bytes;
        logic [63:0] free_address;
    } t_in_word;

    typedef struct packed {
        logic [63:0] address;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PREP, S_SCAN_RD, S_SCAN, S_MARK_RD, S_MARK, S_DONE, S_OUT
    } t_state;
endpackage

FILE: sv/bitmap_page_frame_allocator.sv
// Top level: first-fit bitmap page frame allocator with word-serial map walk
//  channel | dir | handshake          | payload
//  in      | in  | i_valid / o_stall  | i_data   (bpfa_pkg::t_in_word)
//  out     | out | o_valid / i_stall  | o_data   (bpfa_pkg::t_out_word)
//  cfg     | in  | i_cfg_we           | i_cfg_idx, i_cfg_data
// After reset a clearing pass zeroes all WORDS (64) map words; no word taken then.
// Allocate walks the map one word at a time (S_SCAN_RD read, then S_SCAN), then marks the run.
// Free rewrites up to ceil(pages/64)+1 map words, each read in S_MARK_RD and written in S_MARK.
// One item at a time; the result register holds while i_stall is high.
`include "assert_macros.svh"
module bitmap_page_frame_allocator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  bpfa_pkg::t_in_word    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output bpfa_pkg::t_out_word   o_data,
    input  logic                  i_cfg_we,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]           i_cfg_data
);
    localparam int WA = bpfa_pkg::WA_W;
    localparam int PW = bpfa_pkg::PG_W;
    localparam int HB = 64 - bpfa_pkg::PAGE_SHIFT;

    logic [63:0] mem [bpfa_pkg::WORDS];
    logic [63:0] r_rdata;

    bpfa_pkg::t_state r_state, n_state;
    logic [51:0] r_base;
    logic [bpfa_pkg::RP_W-1:0] r_rpages;
    logic [63:0] r_woff;

    logic          r_op, n_op;
    logic [PW-1:0] r_need, n_need;
    logic [PW-1:0] r_n, n_n;
    logic [PW-1:0] r_p, n_p;        // current page (word aligned in scan)
    logic [PW-1:0] r_run, n_run;
    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_stop, n_stop;
    logic [63:0]   r_phys, n_phys;
    logic [63:0]   r_res_addr, n_res_addr;
    logic [1:0]    r_res_st, n_res_st;
    logic          r_ovalid, n_ovalid;
    logic [WA-1:0] r_clr, n_clr;

    logic          we;
    logic [WA-1:0] waddr, raddr;
    logic [63:0]   wdata;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_rpages <= bpfa_pkg::RP_W'(4096);
            r_woff <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpfa_pkg::CFG_REGION_BASE:   r_base <= i_cfg_data[51:0];
                bpfa_pkg::CFG_REGION_PAGES:  r_rpages <= i_cfg_data[bpfa_pkg::RP_W-1:0];
                bpfa_pkg::CFG_WINDOW_OFFSET: r_woff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan helpers over one word
    logic [6:0]  scan_cnt;   // bits of word valid within region
    logic        sc_found;
    logic [PW-1:0] sc_run, sc_start;
    logic [6:0]  lu [64];    // highest used bit at or below each bit, top bit = any
    logic [PW-1:0] run_len [64];
    logic [5:0]  hit;
    logic [63:0] mark_mask;
    logic [PW-1:0] wlo, whi, lo, hi;
    logic [PW-1:0] need_pages;
    logic [PW-1:0] usable;
    logic [63:0] rel;
    logic [HB-1:0] hi_bits;

    assign usable = (PW'(r_rpages) > PW'(bpfa_pkg::PAGES)) ? PW'(bpfa_pkg::PAGES) : PW'(r_rpages);
    assign need_pages = 33'(i_data.size_bytes) + 33'((1 << bpfa_pkg::PAGE_SHIFT) - 1)
                        >> bpfa_pkg::PAGE_SHIFT > 33'(bpfa_pkg::PAGES)
                        ? PW'(bpfa_pkg::PAGES + 1)
                        : PW'((33'(i_data.size_bytes) + 33'((1 << bpfa_pkg::PAGE_SHIFT) - 1))
                              >> bpfa_pkg::PAGE_SHIFT);

    // free run ending at each bit from a log-depth scan of the last used bit
    always_comb begin
        scan_cnt = ((r_n - r_p) >= PW'(64)) ? 7'd64 : 7'(r_n - r_p);
        for (int b = 0; b < 64; b++)
            lu[b] = r_rdata[b] ? {1'b1, 6'(b)} : 7'd0;
        for (int d = 1; d < 64; d = d * 2) begin
            for (int b = 63; b >= d; b--) begin
                if (!lu[b][6]) lu[b] = lu[b - d];
            end
        end
        for (int b = 0; b < 64; b++) begin
            if (r_rdata[b]) run_len[b] = '0;
            else if (lu[b][6]) run_len[b] = PW'(6'(b) - lu[b][5:0]);
            else run_len[b] = r_run + PW'(b + 1);
        end
        // first bit where the run reaches the request
        sc_found = 1'b0;
        hit = '0;
        for (int b = 63; b >= 0; b--) begin
            if (7'(b) < scan_cnt && run_len[b] >= r_need) begin
                sc_found = 1'b1;
                hit = 6'(b);
            end
        end
        sc_start = r_p + PW'(hit) + PW'(1) - r_need;
        sc_run = run_len[63];
    end

    // mask of bits of the word at r_p inside [r_start, r_stop)
    always_comb begin
        wlo = {r_p[PW-1:6], 6'd0};
        whi = wlo + PW'(64);
        lo = (r_start > wlo) ? r_start : wlo;
        hi = (r_stop < whi) ? r_stop : whi;
        mark_mask = '0;
        for (int b = 0; b < 64; b++)
            mark_mask[b] = ((wlo + PW'(b)) >= lo) && ((wlo + PW'(b)) < hi);
    end

    assign rel = r_phys - {12'd0, r_base};
    assign hi_bits = rel[63:bpfa_pkg::PAGE_SHIFT];

    always_comb begin
        n_state = r_state;
        n_op = r_op; n_need = r_need; n_n = r_n; n_p = r_p; n_run = r_run;
        n_start = r_start; n_stop = r_stop; n_phys = r_phys;
        n_res_addr = r_res_addr; n_res_st = r_res_st; n_ovalid = r_ovalid;
        n_clr = r_clr;
        we = 1'b0; waddr = r_p[WA+5:6]; wdata = '0; raddr = r_p[WA+5:6];
        o_stall = 1'b1;
        case (r_state)
            bpfa_pkg::S_CLEAR: begin
                we = 1'b1; waddr = r_clr; wdata = '0;
                n_clr = r_clr + WA'(1);
                if (r_clr == WA'(bpfa_pkg::WORDS - 1)) n_state = bpfa_pkg::S_IDLE;
            end
            bpfa_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_op = i_data.opcode;
                    n_need = need_pages;
                    n_n = usable;
                    n_phys = i_data.free_address - r_woff;
                    n_p = '0; n_run = '0; n_start = '0;
                    n_state = bpfa_pkg::S_PREP;
                end
            end
            bpfa_pkg::S_PREP: begin
                n_res_addr = '0; n_res_st = bpfa_pkg::ST_OK;
                if (r_op == bpfa_pkg::OP_ALLOC) begin
                    if (r_need == '0 || r_need > r_n) begin
                        n_res_st = bpfa_pkg::ST_NOFIT; n_state = bpfa_pkg::S_DONE;
                    end else n_state = bpfa_pkg::S_SCAN_RD;
                end else begin
                    if (r_phys < {12'd0, r_base} || hi_bits >= HB'(r_n)) begin
                        n_res_st = bpfa_pkg::ST_RANGE; n_state = bpfa_pkg::S_DONE;
                    end else begin
                        n_start = PW'(hi_bits);
                        n_stop = (r_need > r_n - PW'(hi_bits)) ? r_n : PW'(hi_bits) + r_need;
                        n_p = PW'(hi_bits);
                        n_state = bpfa_pkg::S_MARK_RD;
                    end
                end
            end
            bpfa_pkg::S_SCAN_RD: n_state = bpfa_pkg::S_SCAN;
            bpfa_pkg::S_SCAN: begin
                n_run = sc_run; n_start = sc_start;
                if (sc_found) begin
                    n_stop = sc_start + r_need;
                    n_p = sc_start;
                    n_res_addr = {12'd0, r_base} + (64'(sc_start) << bpfa_pkg::PAGE_SHIFT) + r_woff;
                    n_state = bpfa_pkg::S_MARK_RD;
                end else if (r_p + PW'(64) >= r_n) begin
                    n_res_st = bpfa_pkg::ST_NOFIT; n_state = bpfa_pkg::S_DONE;
                end else begin
                    n_p = r_p + PW'(64); n_state = bpfa_pkg::S_SCAN_RD;
                end
            end
            bpfa_pkg::S_MARK_RD: n_state = bpfa_pkg::S_MARK;
            bpfa_pkg::S_MARK: begin
                we = (r_start < r_stop);
                wdata = (r_op == bpfa_pkg::OP_ALLOC) ? (r_rdata | mark_mask) : (r_rdata & ~mark_mask);
                if (whi >= r_stop) n_state = bpfa_pkg::S_DONE;
                else begin
                    n_p = whi; n_state = bpfa_pkg::S_MARK_RD;
                end
            end
            bpfa_pkg::S_DONE: begin
                n_ovalid = 1'b1; n_state = bpfa_pkg::S_OUT;
            end
            bpfa_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0; n_state = bpfa_pkg::S_IDLE;
                end
            end
            default: n_state = bpfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpfa_pkg::S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_need <= n_need; r_n <= n_n; r_p <= n_p; r_run <= n_run;
        r_start <= n_start; r_stop <= n_stop; r_phys <= n_phys;
        r_res_addr <= n_res_addr; r_res_st <= n_res_st;
    end

    assign o_valid = r_ovalid;
    assign o_data.address = r_res_addr;
    assign o_data.status = r_res_st;

    `CHK_IMPL(a_valid_out, i_clk, i_rst_n, o_valid, r_state == bpfa_pkg::S_OUT, "valid outside output state")
    `CHK_IMPL(a_busy_stall, i_clk, i_rst_n, r_state != bpfa_pkg::S_IDLE, o_stall, "input taken while busy")
    `CHK_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && o_data.status != bpfa_pkg::ST_OK, o_data.address == 64'd0, "failure with address")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "result changed under stall")
endmodule
